// File: rtl/core/cbwfc_pkg.sv
// Shared types and codes for the CBOR well-formedness checker.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps
package cbwfc_pkg;

    localparam logic [3:0] STAT_OK       = 4'd0;
    localparam logic [3:0] STAT_TRUNC    = 4'd1;
    localparam logic [3:0] STAT_BADLEN   = 4'd2;
    localparam logic [3:0] STAT_BADCHUNK = 4'd3;
    localparam logic [3:0] STAT_UNDEF    = 4'd4;
    localparam logic [3:0] STAT_HALF     = 4'd5;
    localparam logic [3:0] STAT_SINGLE   = 4'd6;
    localparam logic [3:0] STAT_BREAK    = 4'd7;
    localparam logic [3:0] STAT_SIMPLE   = 4'd8;
    localparam logic [3:0] STAT_GARBAGE  = 4'd9;
    localparam logic [3:0] STAT_DEEP     = 4'd10;

    localparam logic [4:0] INFO_1BYTE = 5'd24;
    localparam logic [4:0] INFO_2BYTE = 5'd25;
    localparam logic [4:0] INFO_4BYTE = 5'd26;
    localparam logic [4:0] INFO_RSVD  = 5'd28;
    localparam logic [4:0] INFO_INDEF = 5'd31;
    localparam logic [7:0] BREAK_BYTE = 8'hFF;

    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_BSTR  = 3'd2;
    localparam logic [2:0] MT_TSTR  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP   = 3'd5;
    localparam logic [2:0] MT_TAG   = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    localparam logic [4:0] SV_FALSE  = 5'd20;
    localparam logic [4:0] SV_TRUE   = 5'd21;
    localparam logic [4:0] SV_NULL   = 5'd22;
    localparam logic [4:0] SV_UNDEF  = 5'd23;
    localparam logic [4:0] SV_DOUBLE = 5'd27;

    typedef enum logic [5:0] {
        PH_HEAD    = 6'b000001,
        PH_TAGGED  = 6'b000010,
        PH_ARG     = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_DONE    = 6'b010000,
        PH_ERROR   = 6'b100000
    } phase_t;

    typedef enum logic [3:0] {
        FK_NONE     = 4'd0,
        FK_ARR_DEF  = 4'd1,
        FK_MAP_KEY  = 4'd2,
        FK_MAP_VAL  = 4'd3,
        FK_ARR_IND  = 4'd4,
        FK_MIND_KEY = 4'd5,
        FK_MIND_VAL = 4'd6,
        FK_BSTR_IND = 4'd7,
        FK_TSTR_IND = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] rem;
    } frame_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic reload;
        logic close;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_final;
        logic exec_pop;
        logic exec_close;
        logic close_pop;
    } stat_t;

endpackage

// File: rtl/core/cbwfc_ctrl.sv
// Sequencing controller: byte capture, byte step, frame close cascade, result.
// Depends on cbwfc_pkg.
`timescale 1ns / 1ps
module cbwfc_ctrl
    import cbwfc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [4:0] {
        C_IDLE   = 5'b00001,
        C_EXEC   = 5'b00010,
        C_RELOAD = 5'b00100,
        C_CLOSE  = 5'b01000,
        C_EMIT   = 5'b10000
    } cstate_t;

    cstate_t state_reg, state_next;
    logic    m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            C_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = C_EXEC;
                end
            end
            C_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.exec_pop) begin
                    state_next = C_RELOAD;
                end else if (stat.exec_close) begin
                    state_next = C_CLOSE;
                end else begin
                    state_next = stat.is_final ? C_EMIT : C_IDLE;
                end
            end
            C_RELOAD: begin
                // popped: new top comes from the frame memory read
                cmd.reload = 1'b1;
                state_next = C_CLOSE;
            end
            C_CLOSE: begin
                cmd.close = 1'b1;
                if (stat.close_pop) begin
                    state_next = C_RELOAD;
                end else begin
                    state_next = stat.is_final ? C_EMIT : C_IDLE;
                end
            end
            C_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= C_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/core/cbwfc_dp.sv
// Datapath: parse state, argument and payload counters, frame stack, result.
// Depends on cbwfc_pkg; driven by cbwfc_ctrl commands.
`timescale 1ns / 1ps
module cbwfc_dp
    import cbwfc_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  in_byte,
    input  logic        is_final,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic [3:0]  out_status,
    output logic [31:0] out_position
);

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int LW = (DW > 5) ? DW : 5;

    logic [7:0]    byte_reg;
    logic          final_reg;
    phase_t        phase_reg;
    logic [3:0]    left_reg;
    logic [63:0]   arg_reg;
    logic [7:0]    pend_reg;
    logic [63:0]   pl_reg;
    logic [DW-1:0] depth_reg;
    kind_t         top_kind_reg;
    logic [63:0]   top_rem_reg;
    logic [31:0]   pos_reg;
    logic [3:0]    fst_reg;
    logic [31:0]   fpos_reg;
    logic [4:0]    nl_reg;
    frame_t        rd_reg;
    logic [3:0]    out_status_reg;
    logic [31:0]   out_pos_reg;

    frame_t        mem [MAX_DEPTH];

    logic [4:0]    info;
    logic [2:0]    mtype;
    kind_t         top;
    logic          after_tag;
    logic          sa;
    logic          hc_go;
    logic [2:0]    hc_type;
    logic [63:0]   hc_arg;
    phase_t        x_phase;
    logic          x_err;
    logic [3:0]    x_code;
    logic          x_push;
    kind_t         x_pkind;
    logic [63:0]   x_pcount;
    logic          x_pop;
    logic          x_close;
    logic [63:0]   x_pl;
    logic [63:0]   x_arg;
    logic [3:0]    x_left;
    logic [7:0]    x_pend;
    logic [LW-1:0] lim;
    logic [DW-1:0] dm1, dm2;

    logic          c_pop;
    kind_t         c_kind;
    logic [63:0]   c_rem;
    logic [63:0]   rem_dec;

    assign info  = byte_reg[4:0];
    assign mtype = byte_reg[7:5];
    assign top   = (depth_reg != '0) ? top_kind_reg : FK_NONE;
    assign dm1   = depth_reg - DW'(1);
    assign dm2   = depth_reg - DW'(2);
    assign lim   = (LW'(nl_reg) > LW'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : LW'(nl_reg);

    // one byte step
    always_comb begin
        after_tag = (phase_reg == PH_TAGGED);
        sa       = 1'b0;
        hc_go    = 1'b0;
        hc_type  = MT_UINT;
        hc_arg   = '0;
        x_phase  = phase_reg;
        x_err    = 1'b0;
        x_code   = STAT_OK;
        x_push   = 1'b0;
        x_pkind  = FK_NONE;
        x_pcount = '0;
        x_pop    = 1'b0;
        x_close  = 1'b0;
        x_pl     = pl_reg;
        x_arg    = arg_reg;
        x_left   = left_reg;
        x_pend   = pend_reg;
        case (phase_reg)
            PH_HEAD, PH_TAGGED: begin
                if (!after_tag && (top == FK_BSTR_IND || top == FK_TSTR_IND)) begin
                    if (byte_reg == BREAK_BYTE) begin
                        x_pop   = 1'b1;
                        x_close = 1'b1;
                    end else if (mtype != ((top == FK_BSTR_IND) ? MT_BSTR : MT_TSTR)) begin
                        x_err  = 1'b1;
                        x_code = STAT_BADCHUNK;
                    end else if (info >= INFO_RSVD) begin
                        x_err  = 1'b1;
                        x_code = STAT_BADLEN;
                    end else begin
                        sa = 1'b1;
                    end
                end else if (mtype == MT_SIMPLE) begin
                    if (info == SV_FALSE || info == SV_TRUE || info == SV_NULL) begin
                        x_close = 1'b1;
                    end else if (info == SV_UNDEF) begin
                        x_err  = 1'b1;
                        x_code = STAT_UNDEF;
                    end else if (info == INFO_2BYTE) begin
                        x_err  = 1'b1;
                        x_code = STAT_HALF;
                    end else if (info == INFO_4BYTE) begin
                        x_err  = 1'b1;
                        x_code = STAT_SINGLE;
                    end else if (info == SV_DOUBLE) begin
                        x_pl    = 64'd8;
                        x_phase = PH_PAYLOAD;
                    end else if (info == INFO_INDEF) begin
                        if (!after_tag && (top == FK_ARR_IND || top == FK_MIND_KEY)) begin
                            x_pop   = 1'b1;
                            x_close = 1'b1;
                        end else begin
                            x_err  = 1'b1;
                            x_code = STAT_BREAK;
                        end
                    end else begin
                        x_err  = 1'b1;
                        x_code = STAT_SIMPLE;
                    end
                end else if (info == INFO_INDEF && mtype >= MT_BSTR && mtype <= MT_MAP) begin
                    x_push = 1'b1;
                    case (mtype)
                        MT_BSTR:  x_pkind = FK_BSTR_IND;
                        MT_TSTR:  x_pkind = FK_TSTR_IND;
                        MT_ARRAY: x_pkind = FK_ARR_IND;
                        default:  x_pkind = FK_MIND_KEY;
                    endcase
                end else if (info >= INFO_RSVD) begin
                    x_err  = 1'b1;
                    x_code = STAT_BADLEN;
                end else begin
                    sa = 1'b1;
                end
                if (sa) begin
                    x_pend = byte_reg;
                    if (info < INFO_1BYTE) begin
                        hc_go   = 1'b1;
                        hc_type = mtype;
                        hc_arg  = 64'(info);
                    end else begin
                        x_arg   = '0;
                        x_phase = PH_ARG;
                        case (info)
                            INFO_1BYTE: x_left = 4'd1;
                            INFO_2BYTE: x_left = 4'd2;
                            INFO_4BYTE: x_left = 4'd4;
                            default:    x_left = 4'd8;
                        endcase
                    end
                end
            end
            PH_ARG: begin
                x_arg  = {arg_reg[55:0], byte_reg};
                x_left = (left_reg != 4'd0) ? left_reg - 4'd1 : left_reg;
                if (x_left == 4'd0) begin
                    hc_go   = 1'b1;
                    hc_type = pend_reg[7:5];
                    hc_arg  = x_arg;
                end
            end
            PH_PAYLOAD: begin
                x_pl = (pl_reg != '0) ? pl_reg - 64'd1 : pl_reg;
                if (x_pl == '0) x_close = 1'b1;
            end
            PH_DONE: begin
                x_err  = 1'b1;
                x_code = STAT_GARBAGE;
            end
            default: ;
        endcase

        if (hc_go) begin
            case (hc_type)
                MT_BSTR, MT_TSTR: begin
                    if (hc_arg == '0) begin
                        x_close = 1'b1;
                    end else begin
                        x_pl    = hc_arg;
                        x_phase = PH_PAYLOAD;
                    end
                end
                MT_ARRAY, MT_MAP: begin
                    if (hc_arg == '0) begin
                        x_close = 1'b1;
                    end else begin
                        x_push   = 1'b1;
                        x_pkind  = (hc_type == MT_ARRAY) ? FK_ARR_DEF : FK_MAP_KEY;
                        x_pcount = hc_arg;
                    end
                end
                MT_TAG:  x_phase = PH_TAGGED;
                default: x_close = 1'b1;
            endcase
        end

        if (x_push) begin
            if (LW'(depth_reg) >= lim) begin
                x_push = 1'b0;
                x_err  = 1'b1;
                x_code = STAT_DEEP;
            end else begin
                x_phase = PH_HEAD;
            end
        end
        if (x_err) x_phase = PH_ERROR;
    end

    // one step of the close cascade on the top frame
    always_comb begin
        c_pop   = 1'b0;
        c_kind  = top_kind_reg;
        c_rem   = top_rem_reg;
        rem_dec = top_rem_reg - 64'd1;
        if (depth_reg != '0) begin
            case (top_kind_reg)
                FK_ARR_DEF: begin
                    if (rem_dec == '0) c_pop = 1'b1;
                    else c_rem = rem_dec;
                end
                FK_MAP_KEY: c_kind = FK_MAP_VAL;
                FK_MAP_VAL: begin
                    if (rem_dec == '0) begin
                        c_pop = 1'b1;
                    end else begin
                        c_rem  = rem_dec;
                        c_kind = FK_MAP_KEY;
                    end
                end
                FK_MIND_KEY: c_kind = FK_MIND_VAL;
                FK_MIND_VAL: c_kind = FK_MIND_KEY;
                default: ;
            endcase
        end
    end

    assign stat.is_final   = final_reg;
    assign stat.exec_pop   = x_pop;
    assign stat.exec_close = x_close;
    assign stat.close_pop  = c_pop;

    // frames below the top; read address tracks the entry under the top
    always_ff @(posedge aclk) begin
        if (cmd.exec && x_push && depth_reg != '0) begin
            mem[dm1[AW-1:0]] <= '{kind: top_kind_reg, rem: top_rem_reg};
        end
        rd_reg <= mem[dm2[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEAD;
            depth_reg <= '0;
            pos_reg   <= '0;
            fst_reg   <= STAT_OK;
            fpos_reg  <= '0;
            nl_reg    <= 5'd16;
        end else begin
            if (cfg_wr_en) nl_reg <= cfg_wr_data;
            if (cmd.exec) begin
                phase_reg <= x_phase;
                if (pos_reg != 32'hFFFF_FFFF) pos_reg <= pos_reg + 32'd1;
                if (x_err) begin
                    fst_reg  <= x_code;
                    fpos_reg <= pos_reg;
                end
                if (x_push) depth_reg <= depth_reg + DW'(1);
                if (x_pop)  depth_reg <= dm1;
            end
            if (cmd.close) begin
                phase_reg <= (depth_reg == '0) ? PH_DONE : PH_HEAD;
                if (c_pop) depth_reg <= dm1;
            end
            if (cmd.emit) begin
                phase_reg <= PH_HEAD;
                depth_reg <= '0;
                pos_reg   <= '0;
                fst_reg   <= STAT_OK;
                fpos_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            byte_reg  <= in_byte;
            final_reg <= is_final;
        end
        if (cmd.exec) begin
            arg_reg  <= x_arg;
            left_reg <= x_left;
            pend_reg <= x_pend;
            pl_reg   <= x_pl;
            if (x_push) begin
                top_kind_reg <= x_pkind;
                top_rem_reg  <= x_pcount;
            end
        end
        if (cmd.close) begin
            top_kind_reg <= c_kind;
            top_rem_reg  <= c_rem;
        end
        if (cmd.reload && depth_reg != '0) begin
            top_kind_reg <= rd_reg.kind;
            top_rem_reg  <= rd_reg.rem;
        end
        if (cmd.emit) begin
            if (phase_reg == PH_ERROR) begin
                out_status_reg <= fst_reg;
                out_pos_reg    <= fpos_reg;
            end else if (phase_reg == PH_DONE) begin
                out_status_reg <= STAT_OK;
                out_pos_reg    <= '0;
            end else begin
                out_status_reg <= STAT_TRUNC;
                out_pos_reg    <= pos_reg;
            end
        end
    end

    assign out_status   = out_status_reg;
    assign out_position = out_pos_reg;

endmodule

// File: rtl/core/cbor_wellformedness_checker.sv
// Each byte taken is captured, then executed; a byte that ends an item adds a close step,
// a break adds a reload and a close step, as does each frame popped by the close cascade.
// After the final byte an emit step registers the result. A new byte is taken only once the
// steps of the last one are done; a result waiting on the output holds back the next one.
// Reset (aresetn, synchronous, active low) clears parse state; nesting limit resets to 16.
// Top level: ties the controller to the datapath. Depends on cbwfc_pkg.
`timescale 1ns / 1ps
module cbor_wellformedness_checker
    import cbwfc_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_is_final,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [31:0] m_error_position,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);

    cmd_t  cmd;
    stat_t stat;

    cbwfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cbwfc_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_byte      (s_in_byte),
        .is_final     (s_is_final),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .stat         (stat),
        .out_status   (m_status),
        .out_position (m_error_position)
    );

endmodule

// File: rtl/core/cbwfc_chk.sv
// Port-level checks on the result channel, bound to the top level.
// Depends on cbwfc_pkg.
`timescale 1ns / 1ps
module cbwfc_chk
    import cbwfc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_status,
    input logic [31:0] m_error_position
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_error_position))
        else $error("result changed while stalled");

    a_ok_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_OK |-> m_error_position == 32'd0)
        else $error("ok result with nonzero position");

    a_trunc_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_TRUNC |-> m_error_position != 32'd0)
        else $error("truncation reported at position zero");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= STAT_DEEP)
        else $error("status code out of range");

endmodule

bind cbor_wellformedness_checker cbwfc_chk u_chk (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_error_position (m_error_position)
);

// File: tb/cbor_result_checker.sv
// Result checker for the CBOR well-formedness checker: watches both channels and the
// config port, predicts status/position per object, compares. Depends on cbwfc_pkg.
`timescale 1ns / 1ps
module cbor_result_checker
    import cbwfc_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_is_final,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_status,
    input  logic [31:0] m_error_position,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] position;
    } verdict_t;

    verdict_t    expected_verdicts[$];

    logic [4:0]  nest_limit;
    phase_t      phase;
    int          arg_left;
    logic [63:0] arg_val;
    logic [7:0]  head;
    logic [63:0] pay_left;
    logic [63:0] frem[MAX_DEPTH];
    kind_t       fkind[MAX_DEPTH];
    int          depth;
    logic [31:0] bpos;
    logic [31:0] cur_pos;
    logic [3:0]  first_stat;
    logic [31:0] first_pos;

    assign outstanding = expected_verdicts.size();

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_parse();
        phase = PH_HEAD;
        arg_left = 0;
        arg_val = '0;
        head = '0;
        pay_left = '0;
        depth = 0;
        bpos = '0;
        first_stat = STAT_OK;
        first_pos = '0;
    endtask

    task automatic raise_err(input logic [3:0] code);
        first_stat = code;
        first_pos = cur_pos;
        phase = PH_ERROR;
    endtask

    task automatic push_frame(input kind_t kind, input logic [63:0] cnt);
        int lim;
        lim = (nest_limit > MAX_DEPTH) ? MAX_DEPTH : int'(nest_limit);
        if (depth >= lim) begin
            raise_err(STAT_DEEP);
        end else begin
            fkind[depth] = kind;
            frem[depth] = cnt;
            depth++;
            phase = PH_HEAD;
        end
    endtask

    // an item finished: pop every container it completes
    task automatic close_items();
        int t;
        phase = PH_HEAD;
        while (1'b1) begin
            if (depth == 0) begin
                phase = PH_DONE;
                return;
            end
            t = depth - 1;
            case (fkind[t])
                FK_ARR_DEF: begin
                    frem[t]--;
                    if (frem[t] == 0) depth--;
                    else return;
                end
                FK_MAP_KEY: begin
                    fkind[t] = FK_MAP_VAL;
                    return;
                end
                FK_MAP_VAL: begin
                    frem[t]--;
                    if (frem[t] == 0) depth--;
                    else begin
                        fkind[t] = FK_MAP_KEY;
                        return;
                    end
                end
                FK_MIND_KEY: begin
                    fkind[t] = FK_MIND_VAL;
                    return;
                end
                FK_MIND_VAL: begin
                    fkind[t] = FK_MIND_KEY;
                    return;
                end
                default: return;
            endcase
        end
    endtask

    task automatic head_done(input logic [63:0] arg);
        case (head[7:5])
            MT_BSTR, MT_TSTR: begin
                if (arg == 0) close_items();
                else begin
                    pay_left = arg;
                    phase = PH_PAYLOAD;
                end
            end
            MT_ARRAY: if (arg == 0) close_items(); else push_frame(FK_ARR_DEF, arg);
            MT_MAP:   if (arg == 0) close_items(); else push_frame(FK_MAP_KEY, arg);
            MT_TAG:   phase = PH_TAGGED;
            default:  close_items();
        endcase
    endtask

    task automatic start_arg(input logic [7:0] b);
        head = b;
        if (b[4:0] < INFO_1BYTE) begin
            head_done({59'd0, b[4:0]});
        end else begin
            arg_val = '0;
            arg_left = (b[4:0] == INFO_1BYTE) ? 1 : (b[4:0] == INFO_2BYTE) ? 2 :
                       (b[4:0] == INFO_4BYTE) ? 4 : 8;
            phase = PH_ARG;
        end
    endtask

    task automatic take_head(input logic [7:0] b, input logic after_tag);
        logic [2:0] mt;
        logic [4:0] info;
        kind_t      top;
        mt = b[7:5];
        info = b[4:0];
        top = (depth > 0) ? fkind[depth-1] : FK_NONE;
        if (!after_tag && (top == FK_BSTR_IND || top == FK_TSTR_IND)) begin
            if (b == BREAK_BYTE) begin
                depth--;
                close_items();
            end else if (mt != ((top == FK_BSTR_IND) ? MT_BSTR : MT_TSTR)) begin
                raise_err(STAT_BADCHUNK);
            end else if (info >= INFO_RSVD) begin
                raise_err(STAT_BADLEN);
            end else begin
                start_arg(b);
            end
            return;
        end
        if (mt == MT_SIMPLE) begin
            case (info)
                SV_FALSE, SV_TRUE, SV_NULL: close_items();
                SV_UNDEF:   raise_err(STAT_UNDEF);
                INFO_2BYTE: raise_err(STAT_HALF);
                INFO_4BYTE: raise_err(STAT_SINGLE);
                SV_DOUBLE: begin
                    pay_left = 64'd8;
                    phase = PH_PAYLOAD;
                end
                INFO_INDEF: begin
                    if (!after_tag && (top == FK_ARR_IND || top == FK_MIND_KEY)) begin
                        depth--;
                        close_items();
                    end else begin
                        raise_err(STAT_BREAK);
                    end
                end
                default: raise_err(STAT_SIMPLE);
            endcase
            return;
        end
        if (info == INFO_INDEF) begin
            case (mt)
                MT_BSTR:  begin push_frame(FK_BSTR_IND, '0); return; end
                MT_TSTR:  begin push_frame(FK_TSTR_IND, '0); return; end
                MT_ARRAY: begin push_frame(FK_ARR_IND, '0);  return; end
                MT_MAP:   begin push_frame(FK_MIND_KEY, '0); return; end
                default: ;
            endcase
        end
        if (info >= INFO_RSVD) raise_err(STAT_BADLEN);
        else start_arg(b);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic fin);
        verdict_t v;
        cur_pos = bpos;
        case (phase)
            PH_HEAD:   take_head(b, 1'b0);
            PH_TAGGED: take_head(b, 1'b1);
            PH_ARG: begin
                arg_val = {arg_val[55:0], b};
                if (arg_left > 0) arg_left--;
                if (arg_left == 0) head_done(arg_val);
            end
            PH_PAYLOAD: begin
                if (pay_left != 0) pay_left--;
                if (pay_left == 0) close_items();
            end
            PH_DONE: raise_err(STAT_GARBAGE);
            default: ;
        endcase
        if (bpos != 32'hFFFF_FFFF) bpos++;
        if (fin) begin
            if (phase == PH_ERROR) v = '{first_stat, first_pos};
            else if (phase == PH_DONE) v = '{STAT_OK, 32'd0};
            else v = '{STAT_TRUNC, bpos};
            expected_verdicts = {expected_verdicts, v};
            clear_parse();
        end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            nest_limit = 5'd16;
            clear_parse();
            expected_verdicts.delete();
        end else begin
            if (cfg_wr_en) nest_limit = cfg_wr_data;
            if (s_valid && s_ready) predict_byte(s_in_byte, s_is_final);
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d pos %0d",
                                              m_status, m_error_position));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_status, want.status));
                    if (m_error_position !== want.position)
                        report_mismatch($sformatf("error position %0d, want %0d",
                                                  m_error_position, want.position));
                end
            end
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the CBOR well-formedness checker bench: clock, reset, byte stimulus, config
// phases, watchdog and verdict. Depends on cbwfc_pkg and cbor_result_checker.
`timescale 1ns / 1ps
module testbench;
    import cbwfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int BYTES_PER_PHASE = 56;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = '0;
    logic        s_is_final = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic [31:0] m_error_position;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;

    int          fail_count;
    int          outstanding;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          idle_cycles = 0;
    int          bytes_sent = 0;
    logic [7:0]  obj[$];

    always #10 aclk = ~aclk;

    cbor_wellformedness_checker i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_in_byte, .s_is_final,
        .m_valid, .m_ready, .m_status, .m_error_position, .cfg_wr_en, .cfg_wr_data
    );

    cbor_result_checker i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_in_byte, .s_is_final,
        .m_valid, .m_ready, .m_status, .m_error_position, .cfg_wr_en, .cfg_wr_data,
        .fail_count, .outstanding
    );

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved in %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic append_byte(input logic [7:0] b);
        obj = {obj, b};
    endtask

    // entered and left just after a rising edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_is_final <= fin;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        bytes_sent++;
    endtask

    task automatic send_obj();
        foreach (obj[i]) send_byte(obj[i], i == obj.size() - 1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic emit_head(input logic [2:0] mt, input logic [63:0] val);
        int k;
        if (val < 24 && $urandom_range(2) != 0) begin
            append_byte({mt, val[4:0]});
            return;
        end
        k = (val < 256) ? 0 : (val < 65536) ? 1 : (val < 64'h1_0000_0000) ? 2 : 3;
        if ($urandom_range(3) == 0) k = $urandom_range(3, k);
        append_byte({mt, 5'(24 + k)});
        for (int i = (1 << k) - 1; i >= 0; i--) append_byte(val[8*i +: 8]);
    endtask

    task automatic gen_value(input int lvl);
        int kind, n;
        logic [2:0] mt;
        kind = $urandom_range(lvl >= 4 ? 3 : 9);
        mt = $urandom_range(1) ? MT_TSTR : MT_BSTR;
        case (kind)
            0, 1: emit_head(3'(kind), {$urandom, $urandom} >> $urandom_range(63));
            2: begin
                if ($urandom_range(3) == 0) begin
                    append_byte({MT_SIMPLE, SV_DOUBLE});
                    repeat (8) append_byte(8'($urandom));
                end else begin
                    append_byte({MT_SIMPLE, 5'($urandom_range(SV_FALSE, SV_NULL))});
                end
            end
            3: begin
                n = $urandom_range(4);
                emit_head(mt, 64'(n));
                repeat (n) append_byte(8'($urandom));
            end
            4: begin
                append_byte({mt, INFO_INDEF});
                repeat ($urandom_range(2)) begin
                    n = $urandom_range(3);
                    emit_head(mt, 64'(n));
                    repeat (n) append_byte(8'($urandom));
                end
                append_byte(BREAK_BYTE);
            end
            5: begin
                n = $urandom_range(3);
                emit_head(MT_ARRAY, 64'(n));
                repeat (n) gen_value(lvl + 1);
            end
            6: begin
                append_byte({MT_ARRAY, INFO_INDEF});
                repeat ($urandom_range(3)) gen_value(lvl + 1);
                append_byte(BREAK_BYTE);
            end
            7: begin
                n = $urandom_range(2);
                emit_head(MT_MAP, 64'(n));
                repeat (2 * n) gen_value(lvl + 1);
            end
            8: begin
                append_byte({MT_MAP, INFO_INDEF});
                repeat (2 * $urandom_range(2)) gen_value(lvl + 1);
                append_byte(BREAK_BYTE);
            end
            default: begin
                emit_head(MT_TAG, 64'($urandom_range(300)));
                gen_value(lvl + 1);
            end
        endcase
    endtask

    task automatic random_object();
        int m;
        obj.delete();
        m = $urandom_range(99);
        if (m < 10) begin
            repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
        end else begin
            gen_value(0);
            if (m < 20 && obj.size() > 1) begin
                obj = obj[0 : $urandom_range(obj.size() - 2)];
            end else if (m < 30) begin
                repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
            end else if (m < 40) begin
                obj[$urandom_range(obj.size() - 1)] = 8'($urandom);
            end
        end
        send_obj();
        // occasionally hold off until every verdict is back
        if ($urandom_range(19) == 0) begin
            s_valid <= 1'b0;
            while (outstanding != 0) @(posedge aclk);
        end
    endtask

    task automatic directed_objects();
        obj = {8'h00};                                   send_obj();
        obj = {8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_obj();
        obj = {8'h1C};                                   send_obj();
        obj = {8'hDF};                                   send_obj();
        obj = {8'hF5};                                   send_obj();
        obj = {8'hF7};                                   send_obj();
        obj = {8'hF9, 8'h00, 8'h00};                     send_obj();
        obj = {8'hFA};                                   send_obj();
        obj = {8'hF8, 8'h20};                            send_obj();
        obj = {8'hFF};                                   send_obj();
        obj = {8'h5F, 8'h61, 8'hFF};                     send_obj();
        obj = {8'h7F, 8'h7F};                            send_obj();
        obj = {8'h5F, 8'h41, 8'hAA, 8'hFF};              send_obj();
        obj = {8'hBF, 8'h00, 8'hFF};                     send_obj();
        obj = {8'hC1, 8'hFF};                            send_obj();
        obj = {8'h81, 8'h00, 8'h00};                     send_obj();
        obj = {8'h82, 8'h00};                            send_obj();
        obj = {8'h80};                                   send_obj();
    endtask

    initial begin
        int limits[6] = '{1, 31, 0, 2, 5, 16};
        int phase_no;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_objects();
        phase_no = 0;
        for (int p = 0; p <= 6; p++) begin
            if (p > 0) begin
                wait_drained();
                cfg_wr_en <= 1'b1;
                cfg_wr_data <= 5'(limits[p-1]);
                @(posedge aclk);
                cfg_wr_en <= 1'b0;
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            phase_no = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < phase_no) random_object();
        end
        wait_drained();
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
